/* design/gfp_pkg.sv */
// ----------------------------------------------------------------------------
// gfp_pkg
// Shared constants and helpers for the gamepad frame poll block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gfp_pkg;

  // frame geometry
  localparam int unsigned FRAME_BYTES = 9;
  localparam int unsigned POS_W       = 4;
  localparam int unsigned LEFT_PLACE  = 3;
  localparam int unsigned RIGHT_PLACE = 4;

  // command bytes
  localparam logic [7:0] CMD_START = 8'h01;
  localparam logic [7:0] CMD_POLL  = 8'h42;
  localparam logic [7:0] CMD_IDLE  = 8'h00;

  // console characters
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] HEX_DIG  = 8'h30;
  localparam logic [7:0] HEX_LET  = 8'h37;

  // direction codes
  localparam logic [7:0] DIR_CODE_0 = 8'hEF;
  localparam logic [7:0] DIR_CODE_1 = 8'hBF;
  localparam logic [7:0] DIR_CODE_2 = 8'h7F;
  localparam logic [7:0] DIR_CODE_3 = 8'hDF;

  localparam logic [7:0] LED_RESET = 8'hFE;

  // character sequence within one item
  localparam int unsigned STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_PREFIX0 = 4'd0;
  localparam logic [STEP_W-1:0] STEP_PREFIX1 = 4'd1;
  localparam logic [STEP_W-1:0] STEP_HI      = 4'd2;
  localparam logic [STEP_W-1:0] STEP_LO      = 4'd3;
  localparam logic [STEP_W-1:0] STEP_SP0     = 4'd4;
  localparam logic [STEP_W-1:0] STEP_SP1     = 4'd5;
  localparam logic [STEP_W-1:0] STEP_CR      = 4'd6;
  localparam logic [STEP_W-1:0] STEP_LF      = 4'd7;
  localparam logic [STEP_W-1:0] STEP_LEFT    = 4'd8;
  localparam logic [STEP_W-1:0] STEP_RIGHT   = 4'd9;

  typedef struct packed {
    logic       hit;
    logic [1:0] idx;
  } pad_dec_t;

  // upper-case hex digit of a nibble
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] wide;
    wide = {4'h0, nib};
    return (nib < 4'd10) ? (wide + HEX_DIG) : (wide + HEX_LET);
  endfunction

  // direction code lookup
  function automatic pad_dec_t pad_decode(input logic [7:0] code);
    pad_dec_t d;
    d = '{hit: 1'b1, idx: 2'd0};
    unique case (code)
      DIR_CODE_0: d.idx = 2'd0;
      DIR_CODE_1: d.idx = 2'd1;
      DIR_CODE_2: d.idx = 2'd2;
      DIR_CODE_3: d.idx = 2'd3;
      default:    d.hit = 1'b0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

/* design/gfp_if.sv */
// ----------------------------------------------------------------------------
// gfp_if
// Valid/ready channels for reply bytes in and console results out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface gfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] reply_byte;

  modport source (output valid, output reply_byte, input ready);
  modport sink   (input valid, input reply_byte, output ready);
endinterface

interface gfp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic [7:0] next_command;
  logic [7:0] led_state;
  logic       frame_end;
  logic       last;

  modport source (output valid, output text_char, output next_command,
                  output led_state, output frame_end, output last, input ready);
  modport sink   (input valid, input text_char, input next_command,
                  input led_state, input frame_end, input last, output ready);
endinterface

`default_nettype wire

/* design/gamepad_frame_poll.sv */
// ----------------------------------------------------------------------------
// gamepad_frame_poll
// Frame sequencer for a gamepad poll with hex console echo.
// ----------------------------------------------------------------------------
// Each reply byte is held in an item register and played out as console
// characters, one result transfer per cycle while the output is not stalled,
// through a registered output: six characters "0xHH  " inside the frame, and
// at the frame's last place CR LF plus up to two raw echo bytes for matching
// direction codes (eight to ten results), sequenced by the step counter; the
// next reply byte is taken in the cycle the current item's last character
// moves to the output register, so items follow without gaps.
`timescale 1ns / 1ps
`default_nettype none

module gamepad_frame_poll (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  gfp_in_if.sink     req_i,
  gfp_out_if.source  rsp_o
);

  // frame and pad state
  logic [gfp_pkg::POS_W-1:0] pos_q, pos_d;
  logic [7:0]                lcode_q, lcode_d;
  logic [7:0]                rcode_q, rcode_d;
  logic [7:0]                led_q, led_d;

  // item register
  logic                       busy_q, busy_d;
  logic [gfp_pkg::STEP_W-1:0] step_q, step_d;
  logic [7:0]                 byte_q;
  logic                       end_q;
  logic [7:0]                 cmd_q;

  // output register
  logic       ovalid_q, ovalid_d;
  logic [7:0] ochar_q, ochar_d;
  logic [7:0] ocmd_q;
  logic [7:0] oled_q;
  logic       oend_q;
  logic       olast_q, olast_d;

  logic                      in_xfer;
  logic                      adv;
  logic                      is_last;
  logic                      frame_done;
  logic [gfp_pkg::POS_W-1:0] pos_next;
  logic [gfp_pkg::POS_W:0]   pos_inc;
  logic [7:0]                cmd_next;
  gfp_pkg::pad_dec_t         ldec, rdec;
  logic [7:0]                lmask, rmask;
  logic [gfp_pkg::STEP_W-1:0] step_after;

  // frame position and next command
  always_comb begin
    pos_inc    = {1'b0, pos_q} + 1'b1;
    frame_done = pos_inc >= (gfp_pkg::POS_W+1)'(gfp_pkg::FRAME_BYTES);
    pos_next   = frame_done ? '0 : pos_inc[gfp_pkg::POS_W-1:0];
    priority if (pos_next == gfp_pkg::POS_W'(0)) begin
      cmd_next = gfp_pkg::CMD_START;
    end else if (pos_next == gfp_pkg::POS_W'(1)) begin
      cmd_next = gfp_pkg::CMD_POLL;
    end else begin
      cmd_next = gfp_pkg::CMD_IDLE;
    end
  end

  // pad decode
  always_comb begin
    ldec  = gfp_pkg::pad_decode(lcode_q);
    rdec  = gfp_pkg::pad_decode(rcode_q);
    lmask = 8'h01 << {1'b0, ldec.idx};
    rmask = 8'h10 << {1'b0, rdec.idx};
  end

  // step sequencing
  always_comb begin
    adv     = busy_q && (!ovalid_q || rsp_o.ready);
    is_last = 1'b0;
    step_after = step_q + 1'b1;
    unique case (step_q)
      gfp_pkg::STEP_SP1: is_last = !end_q;
      gfp_pkg::STEP_LF: begin
        is_last    = !ldec.hit && !rdec.hit;
        step_after = ldec.hit ? gfp_pkg::STEP_LEFT : gfp_pkg::STEP_RIGHT;
      end
      gfp_pkg::STEP_LEFT:  is_last = !rdec.hit;
      gfp_pkg::STEP_RIGHT: is_last = 1'b1;
      default:             is_last = 1'b0;
    endcase
  end

  assign req_i.ready = !busy_q || (adv && is_last);
  assign in_xfer     = req_i.valid && req_i.ready;

  // next-state logic
  always_comb begin
    pos_d    = pos_q;
    lcode_d  = lcode_q;
    rcode_d  = rcode_q;
    led_d    = led_q;
    busy_d   = busy_q;
    step_d   = step_q;
    ovalid_d = ovalid_q && !rsp_o.ready;
    ochar_d  = ochar_q;
    olast_d  = olast_q;

    // character into output register
    if (adv) begin
      ovalid_d = 1'b1;
      olast_d  = is_last;
      step_d   = step_after;
      if (is_last) begin
        busy_d = 1'b0;
      end
      unique case (step_q)
        gfp_pkg::STEP_PREFIX0: ochar_d = gfp_pkg::CH_ZERO;
        gfp_pkg::STEP_PREFIX1: ochar_d = gfp_pkg::CH_X;
        gfp_pkg::STEP_HI:      ochar_d = gfp_pkg::hex_char(byte_q[7:4]);
        gfp_pkg::STEP_LO:      ochar_d = gfp_pkg::hex_char(byte_q[3:0]);
        gfp_pkg::STEP_SP0,
        gfp_pkg::STEP_SP1:     ochar_d = gfp_pkg::CH_SPACE;
        gfp_pkg::STEP_CR:      ochar_d = gfp_pkg::CH_CR;
        gfp_pkg::STEP_LF:      ochar_d = gfp_pkg::CH_LF;
        gfp_pkg::STEP_LEFT: begin
          ochar_d = lcode_q;
          led_d   = led_q ^ lmask;
        end
        gfp_pkg::STEP_RIGHT: begin
          ochar_d = rcode_q;
          led_d   = led_q ^ rmask;
        end
        default: ochar_d = gfp_pkg::CH_SPACE;
      endcase
    end

    // new reply byte transfer
    if (in_xfer) begin
      busy_d = 1'b1;
      step_d = gfp_pkg::STEP_PREFIX0;
      pos_d  = pos_next;
      if (pos_q == gfp_pkg::POS_W'(gfp_pkg::LEFT_PLACE)) begin
        lcode_d = req_i.reply_byte;
      end
      if (pos_q == gfp_pkg::POS_W'(gfp_pkg::RIGHT_PLACE)) begin
        rcode_d = req_i.reply_byte;
      end
    end
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      lcode_q  <= '0;
      rcode_q  <= '0;
      led_q    <= gfp_pkg::LED_RESET;
      busy_q   <= 1'b0;
      step_q   <= gfp_pkg::STEP_PREFIX0;
      ovalid_q <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      lcode_q  <= lcode_d;
      rcode_q  <= rcode_d;
      led_q    <= led_d;
      busy_q   <= busy_d;
      step_q   <= step_d;
      ovalid_q <= ovalid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      byte_q <= req_i.reply_byte;
      end_q  <= frame_done;
      cmd_q  <= cmd_next;
    end
    if (adv) begin
      ochar_q <= ochar_d;
      olast_q <= olast_d;
      ocmd_q  <= cmd_q;
      oled_q  <= led_d;
      oend_q  <= end_q;
    end
  end

  assign rsp_o.valid        = ovalid_q;
  assign rsp_o.text_char    = ochar_q;
  assign rsp_o.next_command = ocmd_q;
  assign rsp_o.led_state    = oled_q;
  assign rsp_o.frame_end    = oend_q;
  assign rsp_o.last         = olast_q;

endmodule

`default_nettype wire
